// ===== hw/rtl/fihos_pkg.sv =====
// Shared types and constants for the fade-in / hold / fade-out sequencer.
// Used by fihos_div and fade_in_hold_out_sequencer_core; depends on nothing.
package fihos_pkg;

	localparam int DUR_W   = 16;
	localparam int STEP_W  = 17;
	localparam int LEVEL_W = 17;
	localparam int CNT_W   = 5;

	// Full brightness, 1.0 in 1/65536 units
	localparam logic [LEVEL_W-1:0] FULL_LEVEL = 17'h10000;

	// Configuration register indexes
	localparam logic [1:0] CFG_FADE_IN  = 2'd0;
	localparam logic [1:0] CFG_FADE_OUT = 2'd1;
	localparam logic [1:0] CFG_HOLD     = 2'd2;

	// Envelope phases; codes six and seven behave as done
	typedef enum logic [2:0] {
		PH_START = 3'd0,
		PH_PRIME = 3'd1,
		PH_IN    = 3'd2,
		PH_HOLD  = 3'd3,
		PH_OUT   = 3'd4,
		PH_DONE  = 3'd5
	} phase_t;

	// Tick control sequencer
	typedef enum logic [1:0] {
		CTRL_IDLE = 2'd0,
		CTRL_DIV  = 2'd1,
		CTRL_EMIT = 2'd2
	} ctrl_t;

	// Divider status seen by the top level
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== hw/rtl/fade_in_hold_out_sequencer_core.sv =====
// Fade-in / hold / fade-out brightness envelope sequencer, top level.
// Depends on fihos_pkg and fihos_div.
//
// Each accepted item is one refresh tick and yields exactly one result item
// carrying the new level (1/65536 units), a level_set flag and the phase after
// the tick. A tick that computes a fade fraction is accepted, runs through the
// bit-serial divider (one quotient bit per cycle), has its level formed into
// the pending register and is then loaded into the output register once it is
// free. Other ticks skip the divider. One tick is in work at a time; the output
// register lets the next tick be accepted while a result waits to be taken.
// Configuration writes are always ready and should be made while idle.
module fade_in_hold_out_sequencer_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [1:0]                      cfg_index,
	input  logic [fihos_pkg::DUR_W-1:0]     cfg_data,
	// tick input channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [fihos_pkg::DUR_W-1:0]     elapsed_ms,
	input  logic                            stop_hold,
	// result channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [fihos_pkg::LEVEL_W-1:0]   fade_level,
	output logic                            level_set,
	output logic [2:0]                      phase
);

	// configuration registers
	logic [fihos_pkg::DUR_W-1:0]   fade_in_q;
	logic [fihos_pkg::DUR_W-1:0]   fade_out_q;
	logic [fihos_pkg::DUR_W-1:0]   hold_q;

	// envelope state
	fihos_pkg::phase_t             phase_q;
	logic [fihos_pkg::STEP_W-1:0]  step_q;
	logic                          hold_cancelled_q;

	// pending result of the tick in work
	logic [fihos_pkg::LEVEL_W-1:0] pend_level_q;
	logic                          pend_set_q;
	logic                          pend_sub_q;

	// output register
	logic                          out_valid_q;
	logic [fihos_pkg::LEVEL_W-1:0] out_level_q;
	logic                          out_set_q;
	logic [2:0]                    out_phase_q;

	fihos_pkg::ctrl_t              ctrl_q;
	fihos_pkg::ctrl_t              ctrl_d;

	logic                          accept;
	logic                          div_start;
	logic                          out_load;

	// tick decode
	fihos_pkg::phase_t             phase_d;
	logic [fihos_pkg::STEP_W-1:0]  step_d;
	logic [fihos_pkg::STEP_W-1:0]  step_sum;
	logic [fihos_pkg::DUR_W-1:0]   hold_eff;
	logic                          hc_d;
	logic                          need_div;
	logic                          sub_d;
	logic [fihos_pkg::DUR_W-1:0]   div_divisor;
	logic [fihos_pkg::LEVEL_W-1:0] level_d;
	logic                          set_d;

	fihos_pkg::div_stat_t          div_stat;
	logic [fihos_pkg::DUR_W-1:0]   div_quot;
	logic [fihos_pkg::LEVEL_W-1:0] div_level;

	assign cfg_ready = 1'b1;

	// Write configuration registers; ignore unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_in_q  <= '0;
			fade_out_q <= '0;
			hold_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				fihos_pkg::CFG_FADE_IN:  fade_in_q  <= cfg_data;
				fihos_pkg::CFG_FADE_OUT: fade_out_q <= cfg_data;
				fihos_pkg::CFG_HOLD:     hold_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Decode one tick against the current phase
	always_comb begin
		hc_d        = hold_cancelled_q | stop_hold;
		hold_eff    = hc_d ? '0 : hold_q;
		step_sum    = step_q + {1'b0, elapsed_ms};
		phase_d     = phase_q;
		step_d      = step_q;
		level_d     = '0;
		set_d       = 1'b0;
		need_div    = 1'b0;
		sub_d       = 1'b0;
		div_divisor = fade_in_q;
		unique case (phase_q)
			fihos_pkg::PH_START, fihos_pkg::PH_PRIME: begin
				set_d   = fade_in_q != '0;
				step_d  = '0;
				phase_d = (phase_q == fihos_pkg::PH_START) ?
					fihos_pkg::PH_PRIME : fihos_pkg::PH_IN;
			end
			fihos_pkg::PH_IN: begin
				set_d = 1'b1;
				if (step_q < {1'b0, fade_in_q}) begin
					need_div = 1'b1;
					step_d   = step_sum;
				end else begin
					level_d = fihos_pkg::FULL_LEVEL;
					step_d  = '0;
					phase_d = fihos_pkg::PH_HOLD;
				end
			end
			fihos_pkg::PH_HOLD: begin
				if (step_q < {1'b0, hold_eff}) begin
					step_d = step_sum;
				end else begin
					step_d  = '0;
					phase_d = fihos_pkg::PH_OUT;
				end
			end
			fihos_pkg::PH_OUT: begin
				set_d       = 1'b1;
				div_divisor = fade_out_q;
				if (fade_out_q != '0 && step_q < {1'b0, fade_out_q}) begin
					need_div = 1'b1;
					sub_d    = 1'b1;
					step_d   = step_sum;
				end else begin
					level_d = (fade_out_q != '0) ? '0 : fihos_pkg::FULL_LEVEL;
					step_d  = '0;
					phase_d = fihos_pkg::PH_DONE;
				end
			end
			default: ;
		endcase
	end

	// Next state of the tick sequencer
	always_comb begin
		ctrl_d = ctrl_q;
		unique case (ctrl_q)
			fihos_pkg::CTRL_IDLE: begin
				if (accept)
					ctrl_d = need_div ? fihos_pkg::CTRL_DIV : fihos_pkg::CTRL_EMIT;
			end
			fihos_pkg::CTRL_DIV: begin
				if (div_stat.done)
					ctrl_d = fihos_pkg::CTRL_EMIT;
			end
			fihos_pkg::CTRL_EMIT: begin
				if (out_load)
					ctrl_d = fihos_pkg::CTRL_IDLE;
			end
			default: ctrl_d = fihos_pkg::CTRL_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_stall  = ctrl_q != fihos_pkg::CTRL_IDLE;
		accept    = in_valid && !in_stall;
		div_start = accept && need_div;
		out_load  = (ctrl_q == fihos_pkg::CTRL_EMIT) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ctrl_q <= fihos_pkg::CTRL_IDLE;
		else
			ctrl_q <= ctrl_d;
	end

	// Advance envelope state on each accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= fihos_pkg::PH_START;
			step_q           <= '0;
			hold_cancelled_q <= 1'b0;
		end else if (accept) begin
			phase_q          <= phase_d;
			step_q           <= step_d;
			hold_cancelled_q <= hc_d;
		end
	end

	fihos_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (step_q[fihos_pkg::DUR_W-1:0]),
		.divisor  (div_divisor),
		.stat     (div_stat),
		.quot     (div_quot)
	);

	// Turn the quotient into a level, inverted during fade-out
	assign div_level = pend_sub_q ?
		fihos_pkg::FULL_LEVEL - {1'b0, div_quot} : {1'b0, div_quot};

	// Hold the pending result until the output register is free
	always_ff @(posedge clk) begin
		if (accept) begin
			pend_level_q <= level_d;
			pend_set_q   <= set_d;
			pend_sub_q   <= sub_d;
		end else if (ctrl_q == fihos_pkg::CTRL_DIV && div_stat.done) begin
			pend_level_q <= div_level;
		end
	end

	// Output register: valid is control, payload loads with it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_level_q <= pend_level_q;
			out_set_q   <= pend_set_q;
			out_phase_q <= phase_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign fade_level = out_level_q;
	assign level_set  = out_set_q;
	assign phase      = out_phase_q;

endmodule

// ===== hw/rtl/fihos_div.sv =====
// Bit-serial restoring divider: quotient of (dividend << 16) / divisor.
// Requires dividend < divisor. Depends on fihos_pkg.
module fihos_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [fihos_pkg::DUR_W-1:0]  dividend,
	input  logic [fihos_pkg::DUR_W-1:0]  divisor,
	output fihos_pkg::div_stat_t         stat,
	output logic [fihos_pkg::DUR_W-1:0]  quot
);

	logic [fihos_pkg::DUR_W-1:0] rem_q;
	logic [fihos_pkg::DUR_W-1:0] dsr_q;
	logic [fihos_pkg::DUR_W-1:0] quot_q;
	logic [fihos_pkg::CNT_W-1:0] cnt_q;
	logic                        busy_q;
	logic                        done_q;

	logic [fihos_pkg::DUR_W:0]   shifted;
	logic [fihos_pkg::DUR_W:0]   diff;
	logic                        ge;

	// One quotient bit per cycle: shift remainder, trial subtract
	always_comb begin
		shifted = {rem_q, 1'b0};
		ge      = shifted >= {1'b0, dsr_q};
		diff    = shifted - {1'b0, dsr_q};
	end

	// Control: count down the quotient bits, pulse done after the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= fihos_pkg::CNT_W'(fihos_pkg::DUR_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - fihos_pkg::CNT_W'(1);
				if (cnt_q == fihos_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: load operands, then shift quotient bits in
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= dividend;
			dsr_q  <= divisor;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[fihos_pkg::DUR_W-1:0] : shifted[fihos_pkg::DUR_W-1:0];
			quot_q <= {quot_q[fihos_pkg::DUR_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = quot_q;

endmodule
